// ----- hw/rtl/elsc_pkg.sv -----
// Package: types, codes and keyword tables for the expression lexer and syntax checker.
`timescale 1ns / 1ps

package elsc_pkg;

  // Sizes
  localparam int KeywordMaxLen = 7;                  // longest word that can match a keyword
  localparam int CountWidth    = 8;                  // paren counter width
  localparam int CharsW        = 8 * KeywordMaxLen;  // stored leading word bytes
  localparam int ByteIdxW      = $clog2(KeywordMaxLen);
  localparam int LenW          = 8;
  localparam int NumKeywords   = 11;
  localparam int NumHeads      = 4;
  localparam int QueueDepth    = 4;                  // room for one item's worst case plus one
  localparam int QueueCntW     = $clog2(QueueDepth + 1);

  localparam logic [LenW-1:0]       LenMax  = '1;
  localparam logic [CountWidth-1:0] ParenMax = '1;

  // Characters
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_SPACE      = 8'h20;

  // Result kinds
  localparam logic [2:0] KIND_WORD    = 3'd0;
  localparam logic [2:0] KIND_KEYWORD = 3'd1;
  localparam logic [2:0] KIND_CONST   = 3'd2;
  localparam logic [2:0] KIND_SYMBOL  = 3'd3;
  localparam logic [2:0] KIND_VERDICT = 3'd4;

  // Symbol codes
  localparam logic [2:0] SYM_LPAREN = 3'd0;
  localparam logic [2:0] SYM_RPAREN = 3'd1;
  localparam logic [2:0] SYM_COMMA  = 3'd2;
  localparam logic [2:0] SYM_EQUALS = 3'd3;
  localparam logic [2:0] SYM_PLUS   = 3'd4;
  localparam logic [2:0] SYM_MINUS  = 3'd5;
  localparam logic [2:0] SYM_STAR   = 3'd6;
  localparam logic [2:0] SYM_SLASH  = 3'd7;

  // Statement classes; head classes share the first codes
  localparam logic [2:0] STMT_REJECT = 3'd0;
  localparam logic [2:0] STMT_DEF    = 3'd1;
  localparam logic [2:0] STMT_SHOW   = 3'd2;
  localparam logic [2:0] STMT_HELP   = 3'd3;
  localparam logic [2:0] STMT_ASSIGN = 3'd4;
  localparam logic [2:0] STMT_EXPR   = 3'd5;
  localparam logic [2:0] HEAD_NONE   = 3'd0;
  localparam logic [2:0] HEAD_OTHER  = 3'd4;

  // Error bit positions
  localparam int ERR_BADCHAR = 0;
  localparam int ERR_DOTS    = 1;
  localparam int ERR_COMMA   = 2;
  localparam int ERR_PAREN   = 3;
  localparam int ERR_EQUALS  = 4;
  localparam int ERR_EMPTY   = 5;

  typedef enum logic [2:0] {
    CC_WORD,
    CC_CONST,
    CC_SYM,
    CC_SPACE,
    CC_BAD
  } char_class_e;

  typedef enum logic [1:0] {
    TOK_NONE,
    TOK_WORD,
    TOK_CONST
  } tok_class_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] token_length;
    logic [3:0] keyword_index;
    logic [2:0] symbol_code;
    logic [2:0] statement_class;
    logic [5:0] error_bits;
    logic       run_last;
  } out_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] kw;
    logic [2:0] head;
  } close_info_t;

  // Keyword text, first character in the low byte (literals are written reversed)
  localparam logic [CharsW-1:0] KW_TEXT [NumKeywords] = '{
    CharsW'("cnuf"), CharsW'("rav"), CharsW'("pleh"), CharsW'("wohs"),
    CharsW'("nis"), CharsW'("soc"), CharsW'("nat"), CharsW'("trqs"),
    CharsW'("yrotsih"), CharsW'("gl"), CharsW'("sba")
  };
  localparam logic [LenW-1:0] KW_LEN [NumKeywords] = '{
    8'd4, 8'd3, 8'd4, 8'd4, 8'd3, 8'd3, 8'd3, 8'd4, 8'd7, 8'd2, 8'd3
  };

  // Class-giving head words, exact case: Var Func SHOW HELP
  localparam logic [CharsW-1:0] HEAD_TEXT [NumHeads] = '{
    CharsW'("raV"), CharsW'("cnuF"), CharsW'("WOHS"), CharsW'("PLEH")
  };
  localparam logic [LenW-1:0] HEAD_LEN [NumHeads] = '{8'd3, 8'd4, 8'd4, 8'd4};
  localparam logic [2:0] HEAD_CLS [NumHeads] = '{STMT_DEF, STMT_DEF, STMT_SHOW, STMT_HELP};

  function automatic logic [CharsW-1:0] fold_lower(input logic [CharsW-1:0] chars);
    logic [CharsW-1:0] r;
    logic [7:0]        b;
    r = chars;
    for (int i = 0; i < KeywordMaxLen; i++) begin
      b = chars[8*i +: 8];
      if (b >= 8'h41 && b <= 8'h5A) begin
        r[8*i +: 8] = b + 8'h20;
      end
    end
    return r;
  endfunction

  // Classify a token being closed. Bytes past the token length are zero.
  function automatic close_info_t close_eval(input logic [CharsW-1:0] chars,
                                             input logic [LenW-1:0]   len,
                                             input logic              is_word);
    close_info_t       r;
    logic [CharsW-1:0] low;
    logic              short_word;
    low        = fold_lower(chars);
    short_word = (len <= LenW'(KeywordMaxLen));
    r.kind = KIND_CONST;
    r.kw   = '0;
    r.head = HEAD_OTHER;
    if (is_word) begin
      for (int i = 0; i < NumKeywords; i++) begin
        if (short_word && len == KW_LEN[i] && low == KW_TEXT[i]) begin
          r.kw = 4'(i + 1);
        end
      end
      for (int i = 0; i < NumHeads; i++) begin
        if (short_word && len == HEAD_LEN[i] && chars == HEAD_TEXT[i]) begin
          r.head = HEAD_CLS[i];
        end
      end
      r.kind = (r.kw != '0) ? KIND_KEYWORD : KIND_WORD;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/expression_lexer_syntax_checker_core.sv -----
// Top level: byte-stream lexer and line syntax checker with an output queue.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-------------------------------
//   in      | input     | in_valid_i / in_ready_o  | in_data_i  (char byte, line end)
//   out     | output    | out_valid_o / out_ready_i| out_data_o (one token or verdict)
//
// Each byte is decoded, and all of its results are built, in the cycle it is
// accepted; they are registered into a 4-entry output queue. A byte makes
// 0 to 3 result items and the output drains one item per cycle when
// out_ready_i is high, so bytes go in back to back while they average at
// most one result each; otherwise the output sets the pace. in_ready_o is
// high whenever the queue holds at most one item, leaving room for any byte's worst case.
// Reset clears all line state and empties the queue.
// A stall on the output only fills the queue; line state is untouched by it.
`timescale 1ns / 1ps

module expression_lexer_syntax_checker_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  elsc_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output elsc_pkg::out_item_t  out_data_o
);

  // ---------------------------------------------------------------------------
  // Line state
  // ---------------------------------------------------------------------------
  logic [elsc_pkg::CharsW-1:0]     chars_q, chars_d;   // leading bytes of open word
  elsc_pkg::tok_class_e            tok_q, tok_d;       // open token class
  logic [elsc_pkg::LenW-1:0]       len_q, len_d;       // open token length
  logic [1:0]                      dot_q, dot_d;       // dots in open constant, sat 2
  logic [elsc_pkg::CountWidth-1:0] open_q, open_d;     // '(' since last '='
  logic [elsc_pkg::CountWidth-1:0] close_q, close_d;   // ')' since last '='
  logic [1:0]                      eq_q, eq_d;         // '=' count, sat 2
  logic                            comma_q, comma_d;   // comma rule armed
  logic [5:0]                      err_q, err_d;       // error flags so far
  logic [2:0]                      head_q, head_d;     // class from first token
  logic                            any_q, any_d;       // some token seen

  // Output queue: slot 0 is the head
  elsc_pkg::out_item_t             q_q [elsc_pkg::QueueDepth];
  elsc_pkg::out_item_t             q_d [elsc_pkg::QueueDepth];
  logic [elsc_pkg::QueueCntW-1:0]  cnt_q, cnt_d;

  logic take, pop;

  // Byte decode
  elsc_pkg::char_class_e cls;
  logic [2:0]            code;
  logic [7:0]            c;

  assign c = in_data_i.char_byte;

  always_comb begin
    cls  = elsc_pkg::CC_BAD;
    code = elsc_pkg::SYM_LPAREN;
    unique case (c) inside
      [8'h61:8'h7A], [8'h41:8'h5A], elsc_pkg::CH_UNDERSCORE: cls = elsc_pkg::CC_WORD;
      [8'h30:8'h39], elsc_pkg::CH_DOT:                       cls = elsc_pkg::CC_CONST;
      elsc_pkg::CH_SPACE: cls = elsc_pkg::CC_SPACE;
      8'h28: begin cls = elsc_pkg::CC_SYM; code = elsc_pkg::SYM_LPAREN; end
      8'h29: begin cls = elsc_pkg::CC_SYM; code = elsc_pkg::SYM_RPAREN; end
      8'h2C: begin cls = elsc_pkg::CC_SYM; code = elsc_pkg::SYM_COMMA;  end
      8'h3D: begin cls = elsc_pkg::CC_SYM; code = elsc_pkg::SYM_EQUALS; end
      8'h2B: begin cls = elsc_pkg::CC_SYM; code = elsc_pkg::SYM_PLUS;   end
      8'h2D: begin cls = elsc_pkg::CC_SYM; code = elsc_pkg::SYM_MINUS;  end
      8'h2A: begin cls = elsc_pkg::CC_SYM; code = elsc_pkg::SYM_STAR;   end
      8'h2F: begin cls = elsc_pkg::CC_SYM; code = elsc_pkg::SYM_SLASH;  end
      default: cls = elsc_pkg::CC_BAD;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Single-pass update: close old token, handle byte, close at line end, verdict
  // ---------------------------------------------------------------------------
  elsc_pkg::out_item_t   res [3];
  logic [1:0]            nres;
  elsc_pkg::close_info_t ce1, ce2;
  elsc_pkg::out_item_t   cand_a, cand_b, cand_c;
  logic                  a_v, b_v, c_v;
  logic                  is_tok_char;
  logic [2:0]            verdict;

  always_comb begin
    chars_d = chars_q;
    tok_d   = tok_q;
    len_d   = len_q;
    dot_d   = dot_q;
    open_d  = open_q;
    close_d = close_q;
    eq_d    = eq_q;
    comma_d = comma_q;
    err_d   = err_q;
    head_d  = head_q;
    any_d   = any_q;
    cand_a  = '0;
    cand_b  = '0;
    cand_c  = '0;
    b_v     = 1'b0;
    verdict = elsc_pkg::STMT_REJECT;
    is_tok_char = (cls == elsc_pkg::CC_WORD) || (cls == elsc_pkg::CC_CONST);

    // A byte of another class closes the open token
    a_v = (tok_q != elsc_pkg::TOK_NONE) &&
          !(cls == elsc_pkg::CC_WORD && tok_q == elsc_pkg::TOK_WORD) &&
          !(cls == elsc_pkg::CC_CONST && tok_q == elsc_pkg::TOK_CONST);
    ce1 = elsc_pkg::close_eval(chars_q, len_q, tok_q == elsc_pkg::TOK_WORD);
    if (a_v) begin
      if (tok_q == elsc_pkg::TOK_CONST && dot_q == 2'd2) begin
        err_d[elsc_pkg::ERR_DOTS] = 1'b1;
      end
      comma_d = 1'b0;
      if (head_d == elsc_pkg::HEAD_NONE) begin
        head_d = ce1.head;
      end
      any_d = 1'b1;
      cand_a.kind          = ce1.kind;
      cand_a.token_length  = len_q;
      cand_a.keyword_index = ce1.kw;
      cand_a.error_bits    = err_d;
      tok_d   = elsc_pkg::TOK_NONE;
      len_d   = '0;
      dot_d   = '0;
      chars_d = '0;
    end

    // Extend or start a word / constant
    if (is_tok_char) begin
      tok_d = (cls == elsc_pkg::CC_WORD) ? elsc_pkg::TOK_WORD : elsc_pkg::TOK_CONST;
      if (cls == elsc_pkg::CC_WORD && len_d < elsc_pkg::LenW'(elsc_pkg::KeywordMaxLen)) begin
        chars_d[{len_d[elsc_pkg::ByteIdxW-1:0], 3'b000} +: 8] = c;
      end
      if (c == elsc_pkg::CH_DOT && dot_d != 2'd2) begin
        dot_d = dot_d + 2'd1;
      end
      if (len_d != elsc_pkg::LenMax) begin
        len_d = len_d + elsc_pkg::LenW'(1);
      end
    end

    // Symbol
    if (cls == elsc_pkg::CC_SYM) begin
      b_v = 1'b1;
      if (comma_d && code != elsc_pkg::SYM_PLUS && code != elsc_pkg::SYM_MINUS) begin
        err_d[elsc_pkg::ERR_COMMA] = 1'b1;
      end
      case (code)
        elsc_pkg::SYM_LPAREN, elsc_pkg::SYM_RPAREN: begin
          if (code == elsc_pkg::SYM_LPAREN) begin
            if (open_d != elsc_pkg::ParenMax) open_d = open_d + elsc_pkg::CountWidth'(1);
          end else if (close_d != elsc_pkg::ParenMax) begin
            close_d = close_d + elsc_pkg::CountWidth'(1);
          end
          if (close_d > open_d) err_d[elsc_pkg::ERR_PAREN] = 1'b1;
        end
        elsc_pkg::SYM_EQUALS: begin
          if (eq_d != 2'd2) eq_d = eq_d + 2'd1;
          if (close_d != open_d) err_d[elsc_pkg::ERR_PAREN] = 1'b1;
          open_d  = '0;
          close_d = '0;
        end
        elsc_pkg::SYM_COMMA: comma_d = 1'b1;
        default: ;
      endcase
      if (head_d == elsc_pkg::HEAD_NONE) begin
        head_d = elsc_pkg::HEAD_OTHER;
      end
      any_d = 1'b1;
      cand_b.kind         = elsc_pkg::KIND_SYMBOL;
      cand_b.token_length = 8'd1;
      cand_b.symbol_code  = code;
      cand_b.error_bits   = err_d;
    end

    if (cls == elsc_pkg::CC_BAD) begin
      err_d[elsc_pkg::ERR_BADCHAR] = 1'b1;
    end

    // Line end: close what is open, then give the verdict
    c_v = in_data_i.line_end;
    ce2 = elsc_pkg::close_eval(chars_d, len_d, tok_d == elsc_pkg::TOK_WORD);
    if (in_data_i.line_end) begin
      if (is_tok_char) begin
        b_v = 1'b1;
        if (tok_d == elsc_pkg::TOK_CONST && dot_d == 2'd2) begin
          err_d[elsc_pkg::ERR_DOTS] = 1'b1;
        end
        if (head_d == elsc_pkg::HEAD_NONE) begin
          head_d = ce2.head;
        end
        any_d = 1'b1;
        cand_b.kind          = ce2.kind;
        cand_b.token_length  = len_d;
        cand_b.keyword_index = ce2.kw;
        cand_b.symbol_code   = '0;
        cand_b.error_bits    = err_d;
      end
      if (close_d < open_d) err_d[elsc_pkg::ERR_PAREN] = 1'b1;
      if (eq_d == 2'd2)     err_d[elsc_pkg::ERR_EQUALS] = 1'b1;
      if (!any_d)           err_d[elsc_pkg::ERR_EMPTY] = 1'b1;
      if (err_d != '0) begin
        verdict = elsc_pkg::STMT_REJECT;
      end else if (head_d == elsc_pkg::STMT_DEF || head_d == elsc_pkg::STMT_SHOW ||
                   head_d == elsc_pkg::STMT_HELP) begin
        verdict = head_d;
      end else if (eq_d == 2'd1) begin
        verdict = elsc_pkg::STMT_ASSIGN;
      end else begin
        verdict = elsc_pkg::STMT_EXPR;
      end
      cand_c.kind            = elsc_pkg::KIND_VERDICT;
      cand_c.statement_class = verdict;
      cand_c.error_bits      = err_d;
      // new line starts clean
      chars_d = '0;
      tok_d   = elsc_pkg::TOK_NONE;
      len_d   = '0;
      dot_d   = '0;
      open_d  = '0;
      close_d = '0;
      eq_d    = '0;
      comma_d = 1'b0;
      err_d   = '0;
      head_d  = elsc_pkg::HEAD_NONE;
      any_d   = 1'b0;
    end

    // Pack results in order and mark the last
    res[0] = '0;
    res[1] = '0;
    res[2] = '0;
    nres   = '0;
    if (a_v) begin res[nres] = cand_a; nres = nres + 2'd1; end
    if (b_v) begin res[nres] = cand_b; nres = nres + 2'd1; end
    if (c_v) begin res[nres] = cand_c; nres = nres + 2'd1; end
    if (nres != '0) begin
      res[nres - 2'd1].run_last = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Output queue
  // ---------------------------------------------------------------------------
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = q_q[0];
  assign in_ready_o  = (cnt_q <= elsc_pkg::QueueCntW'(1));
  assign take        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  logic [elsc_pkg::QueueCntW-1:0] base;

  always_comb begin
    base = cnt_q - elsc_pkg::QueueCntW'(pop);
    for (int j = 0; j < elsc_pkg::QueueDepth; j++) begin
      q_d[j] = q_q[j];
      if (pop && j < elsc_pkg::QueueDepth - 1) begin
        q_d[j] = q_q[j + 1];
      end
      if (take) begin
        for (int k = 0; k < 3; k++) begin
          if (2'(k) < nres && elsc_pkg::QueueCntW'(j) == base + elsc_pkg::QueueCntW'(k)) begin
            q_d[j] = res[k];
          end
        end
      end
    end
    cnt_d = base + (take ? elsc_pkg::QueueCntW'(nres) : '0);
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < elsc_pkg::QueueDepth; j++) begin
      q_q[j] <= q_d[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      chars_q <= '0;
      tok_q   <= elsc_pkg::TOK_NONE;
      len_q   <= '0;
      dot_q   <= '0;
      open_q  <= '0;
      close_q <= '0;
      eq_q    <= '0;
      comma_q <= 1'b0;
      err_q   <= '0;
      head_q  <= elsc_pkg::HEAD_NONE;
      any_q   <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (take) begin
        chars_q <= chars_d;
        tok_q   <= tok_d;
        len_q   <= len_d;
        dot_q   <= dot_d;
        open_q  <= open_d;
        close_q <= close_d;
        eq_q    <= eq_d;
        comma_q <= comma_d;
        err_q   <= err_d;
        head_q  <= head_d;
        any_q   <= any_d;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= elsc_pkg::QueueCntW'(elsc_pkg::QueueDepth))
    else $error("output queue overflow");

  a_line_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && in_data_i.line_end |=>
      tok_q == elsc_pkg::TOK_NONE && err_q == '0 && !any_q && open_q == '0)
    else $error("line state not cleared after line end");

  a_verdict_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == elsc_pkg::KIND_VERDICT |-> out_data_o.run_last)
    else $error("verdict not marked as last result");

endmodule
